@@ rtl/mccov_pkg.sv @@
// Shared constants, types and helpers for the multichannel covariance matrix core.
// Used by mccov_lane, multichannel_covariance_matrix_core, mccov_checker and the testbench; depends on nothing else.
// Sizes follow from the channel count, the sample width and the maximum window length.
package mccov_pkg;

    // Basic sizes.
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_WINDOW   = 4096;
    localparam int SAMPLE_BITS  = 16;
    localparam int ACC_BITS     = 48;

    // Derived sizes.
    localparam int NUM_ENTRIES = MAX_CHANNELS * (MAX_CHANNELS + 1) / 2;
    localparam int CH_BITS     = $clog2(MAX_CHANNELS);
    localparam int NCH_BITS    = $clog2(MAX_CHANNELS + 1);
    localparam int ENTRY_BITS  = $clog2(NUM_ENTRIES);
    localparam int CNT_BITS    = $clog2(MAX_WINDOW);
    localparam int WLEN_BITS   = 13;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int SUM_BITS    = PROD_BITS + 1;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = WLEN_BITS;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHAN_COUNT    = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [NCH_BITS-1:0]  NCH_RESET  = NCH_BITS'(4);
    localparam logic [WLEN_BITS-1:0] WLEN_RESET = WLEN_BITS'(256);

    // Control that the top level hands to every accumulator lane.
    typedef struct packed {
        logic prod_en;  // capture new products from the input register
        logic acc_en;   // add the held products into the accumulators
        logic win_end;  // this add closes the window, so clear afterwards
    } lane_ctrl_t;

    // Position of entry (r, c), c >= r, in the row-by-row upper triangle.
    function automatic logic [ENTRY_BITS-1:0] entry_index(input logic [CH_BITS-1:0] r,
                                                          input logic [CH_BITS-1:0] c);
        int ri;
        int ci;
        int e;
        ri = int'(r);
        ci = int'(c);
        e  = ri * MAX_CHANNELS - (ri * (ri - 1)) / 2 + ci - ri;
        return ENTRY_BITS'(e);
    endfunction

endpackage

@@ rtl/multichannel_covariance_matrix_core.sv @@
// Top level of the multichannel sample covariance matrix core.
// Depends on mccov_pkg and instantiates one mccov_lane per upper-triangle entry.
// Usage:
//   The input channel (s_valid/s_ready) takes one complex sample per channel in each
//   transfer. Every channel pair is summed over a window of window_length transfers.
//   When a window closes, the result channel (m_valid/m_ready) carries one transfer
//   per upper-triangle entry in use by the channel count, row by row, the diagonal
//   first; m_last_entry marks the final one. The sums then restart from zero.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while idle.
// Timing:
//   An input transfer passes an input register, a product register and the
//   accumulate step; the first entry of a window then passes the snapshot and the
//   output register, and the rest follow one entry per cycle (up to ten) while the
//   receiver is ready. Unless a stall holds them, the product and accumulate stages
//   of the lanes sustain one input transfer per cycle. A closing item waits at the
//   accumulate step until the previous matrix has left its snapshot, so windows of
//   no more transfers than emitted entries are paced by the snapshot readout.
// Reset and stalls:
//   Reset clears the sums, the window count and all valid flags, and restores four
//   channels and a 256-sample window. A stalled receiver holds the output register;
//   that backs up the snapshot, then the accumulate step, then s_ready.
module multichannel_covariance_matrix_core import mccov_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
    // Input sample channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_ch0_re,
    input  logic signed [SAMPLE_BITS-1:0] s_ch0_im,
    input  logic signed [SAMPLE_BITS-1:0] s_ch1_re,
    input  logic signed [SAMPLE_BITS-1:0] s_ch1_im,
    input  logic signed [SAMPLE_BITS-1:0] s_ch2_re,
    input  logic signed [SAMPLE_BITS-1:0] s_ch2_im,
    input  logic signed [SAMPLE_BITS-1:0] s_ch3_re,
    input  logic signed [SAMPLE_BITS-1:0] s_ch3_im,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [CH_BITS-1:0]            m_row,
    output logic [CH_BITS-1:0]            m_col,
    output logic signed [ACC_BITS-1:0]    m_sum_real,
    output logic signed [ACC_BITS-1:0]    m_sum_imag,
    output logic                          m_last_entry
);

    // Configuration registers.
    logic [NCH_BITS-1:0]  chan_count_reg;
    logic [WLEN_BITS-1:0] window_length_reg;
    logic [NCH_BITS-1:0]  nch_eff;
    logic [WLEN_BITS-1:0] wlen_eff;

    // Input register.
    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_re_reg [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] in_im_reg [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] s_re [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] s_im [MAX_CHANNELS];

    // Product stage and window control.
    logic                 prod_valid_reg;
    logic                 prod_ready;
    logic                 acc_fire;
    logic                 win_end;
    logic [CNT_BITS-1:0]  sample_count_reg;
    logic [CNT_BITS-1:0]  sample_count_next;
    logic [WLEN_BITS-1:0] count_inc;
    lane_ctrl_t           lane_ctrl;

    // Lane results and snapshot of a finished matrix.
    logic signed [ACC_BITS-1:0] lane_real [NUM_ENTRIES];
    logic signed [ACC_BITS-1:0] lane_imag [NUM_ENTRIES];
    logic signed [ACC_BITS-1:0] snap_real_reg [NUM_ENTRIES];
    logic signed [ACC_BITS-1:0] snap_imag_reg [NUM_ENTRIES];
    logic                       snap_load;

    // Readout walker and output register.
    logic                    snap_busy_reg;
    logic [CH_BITS-1:0]      emit_row_reg;
    logic [CH_BITS-1:0]      emit_col_reg;
    logic [NCH_BITS-1:0]     col_inc;
    logic [NCH_BITS-1:0]     row_inc;
    logic                    emit;
    logic                    emit_last;
    logic [ENTRY_BITS-1:0]   emit_idx;
    logic                    m_valid_reg;
    logic [CH_BITS-1:0]      m_row_reg;
    logic [CH_BITS-1:0]      m_col_reg;
    logic signed [ACC_BITS-1:0] m_sum_real_reg;
    logic signed [ACC_BITS-1:0] m_sum_imag_reg;
    logic                    m_last_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_count_reg    <= NCH_RESET;
            window_length_reg <= WLEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CHAN_COUNT:    chan_count_reg    <= cfg_wdata[NCH_BITS-1:0];
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_wdata[WLEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range settings clamp to the nearest legal value.
    always_comb begin
        nch_eff = chan_count_reg;
        if (chan_count_reg == '0) begin
            nch_eff = NCH_BITS'(1);
        end else if (chan_count_reg > NCH_BITS'(MAX_CHANNELS)) begin
            nch_eff = NCH_BITS'(MAX_CHANNELS);
        end
        wlen_eff = window_length_reg;
        if (window_length_reg == '0) begin
            wlen_eff = WLEN_BITS'(1);
        end else if (window_length_reg > WLEN_BITS'(MAX_WINDOW)) begin
            wlen_eff = WLEN_BITS'(MAX_WINDOW);
        end
    end

    // Gather the sample ports into arrays.
    assign s_re[0] = s_ch0_re;
    assign s_im[0] = s_ch0_im;
    assign s_re[1] = s_ch1_re;
    assign s_im[1] = s_ch1_im;
    assign s_re[2] = s_ch2_re;
    assign s_im[2] = s_ch2_im;
    assign s_re[3] = s_ch3_re;
    assign s_im[3] = s_ch3_im;

    // Window count: a window closes when the count including this item reaches the length.
    assign count_inc = WLEN_BITS'(sample_count_reg) + WLEN_BITS'(1);
    assign win_end   = (count_inc >= wlen_eff);

    // A closing item waits until the previous matrix has left the snapshot.
    assign acc_fire   = prod_valid_reg && !(win_end && snap_busy_reg);
    assign prod_ready = !prod_valid_reg || acc_fire;
    assign s_ready    = !in_valid_reg || prod_ready;
    assign snap_load  = acc_fire && win_end;

    assign lane_ctrl.prod_en = in_valid_reg && prod_ready;
    assign lane_ctrl.acc_en  = acc_fire;
    assign lane_ctrl.win_end = win_end;

    always_comb begin
        sample_count_next = sample_count_reg;
        if (acc_fire) begin
            sample_count_next = win_end ? '0 : count_inc[CNT_BITS-1:0];
        end
    end

    // Pipeline valid flags and the window count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            prod_valid_reg   <= 1'b0;
            sample_count_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (prod_ready) begin
                prod_valid_reg <= in_valid_reg;
            end
            sample_count_reg <= sample_count_next;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                in_re_reg[ch] <= s_re[ch];
                in_im_reg[ch] <= s_im[ch];
            end
        end
    end

    // One lane per upper-triangle entry, in row-by-row order.
    for (genvar a = 0; a < MAX_CHANNELS; a++) begin : g_row
        for (genvar b = a; b < MAX_CHANNELS; b++) begin : g_col
            localparam int E = a * MAX_CHANNELS - (a * (a - 1)) / 2 + b - a;
            mccov_lane u_lane (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (lane_ctrl),
                .a_re     (in_re_reg[a]),
                .a_im     (in_im_reg[a]),
                .b_re     (in_re_reg[b]),
                .b_im     (in_im_reg[b]),
                .sum_real (lane_real[E]),
                .sum_imag (lane_imag[E])
            );
        end
    end

    // Snapshot of the finished matrix, taken as the lanes clear.
    always_ff @(posedge aclk) begin
        if (snap_load) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                snap_real_reg[e] <= lane_real[e];
                snap_imag_reg[e] <= lane_imag[e];
            end
        end
    end

    // Walk the used entries: along the row, then to the next diagonal.
    assign col_inc   = NCH_BITS'(emit_col_reg) + NCH_BITS'(1);
    assign row_inc   = NCH_BITS'(emit_row_reg) + NCH_BITS'(1);
    assign emit_last = (col_inc >= nch_eff) && (row_inc >= nch_eff);
    assign emit      = snap_busy_reg && (!m_valid_reg || m_ready);
    assign emit_idx  = entry_index(emit_row_reg, emit_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_busy_reg <= 1'b0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
        end else if (snap_load) begin
            snap_busy_reg <= 1'b1;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
        end else if (emit) begin
            priority if (emit_last) begin
                snap_busy_reg <= 1'b0;
            end else if (col_inc < nch_eff) begin
                emit_col_reg <= col_inc[CH_BITS-1:0];
            end else begin
                emit_row_reg <= row_inc[CH_BITS-1:0];
                emit_col_reg <= row_inc[CH_BITS-1:0];
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_row_reg      <= emit_row_reg;
            m_col_reg      <= emit_col_reg;
            m_sum_real_reg <= snap_real_reg[emit_idx];
            m_sum_imag_reg <= (emit_row_reg == emit_col_reg) ? '0 : snap_imag_reg[emit_idx];
            m_last_reg     <= emit_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_row        = m_row_reg;
    assign m_col        = m_col_reg;
    assign m_sum_real   = m_sum_real_reg;
    assign m_sum_imag   = m_sum_imag_reg;
    assign m_last_entry = m_last_reg;

    // A new snapshot never overwrites a matrix still being read out.
    a_snap_free: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_load |-> !snap_busy_reg)
        else $error("snapshot loaded while readout busy");

    // A closing item restarts the window count.
    a_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_load |=> (sample_count_reg == '0))
        else $error("window count not cleared after window end");

    // Emitted entries lie in the upper triangle.
    a_upper: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_col_reg >= m_row_reg))
        else $error("entry below the diagonal emitted");

    // The final entry of a matrix is the last diagonal entry.
    a_last_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_row_reg == m_col_reg))
        else $error("last entry flagged off the diagonal");

endmodule

@@ rtl/mccov_lane.sv @@
// One accumulator lane of the covariance core: x_a times conj(x_b) for a fixed pair.
// Depends on mccov_pkg for sizes and the lane control struct.
// Products are registered, then added into the 48-bit real and imaginary sums.
module mccov_lane import mccov_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lane_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_BITS-1:0] a_re,
    input  logic signed [SAMPLE_BITS-1:0] a_im,
    input  logic signed [SAMPLE_BITS-1:0] b_re,
    input  logic signed [SAMPLE_BITS-1:0] b_im,
    output logic signed [ACC_BITS-1:0]    sum_real,
    output logic signed [ACC_BITS-1:0]    sum_imag
);

    logic signed [PROD_BITS-1:0] rr_reg;
    logic signed [PROD_BITS-1:0] ii_reg;
    logic signed [PROD_BITS-1:0] ir_reg;
    logic signed [PROD_BITS-1:0] ri_reg;
    logic signed [SUM_BITS-1:0]  prod_real;
    logic signed [SUM_BITS-1:0]  prod_imag;
    logic signed [ACC_BITS-1:0]  acc_real_reg;
    logic signed [ACC_BITS-1:0]  acc_imag_reg;
    logic signed [ACC_BITS-1:0]  acc_real_next;
    logic signed [ACC_BITS-1:0]  acc_imag_next;

    // Four partial products of the complex multiply, one multiplier each.
    always_ff @(posedge aclk) begin
        if (ctrl.prod_en) begin
            rr_reg <= PROD_BITS'(a_re) * PROD_BITS'(b_re);
            ii_reg <= PROD_BITS'(a_im) * PROD_BITS'(b_im);
            ir_reg <= PROD_BITS'(a_im) * PROD_BITS'(b_re);
            ri_reg <= PROD_BITS'(a_re) * PROD_BITS'(b_im);
        end
    end

    // Combine into the real and imaginary parts of the product.
    assign prod_real = SUM_BITS'(rr_reg) + SUM_BITS'(ii_reg);
    assign prod_imag = SUM_BITS'(ir_reg) - SUM_BITS'(ri_reg);

    // Running sums including the held product; these also feed the snapshot.
    assign sum_real = acc_real_reg + ACC_BITS'(prod_real);
    assign sum_imag = acc_imag_reg + ACC_BITS'(prod_imag);

    // The accumulators restart from zero once a window closes.
    always_comb begin
        acc_real_next = acc_real_reg;
        acc_imag_next = acc_imag_reg;
        if (ctrl.acc_en) begin
            acc_real_next = ctrl.win_end ? '0 : sum_real;
            acc_imag_next = ctrl.win_end ? '0 : sum_imag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_real_reg <= '0;
            acc_imag_reg <= '0;
        end else begin
            acc_real_reg <= acc_real_next;
            acc_imag_reg <= acc_imag_next;
        end
    end

endmodule

@@ test/mccov_checker.sv @@
// Checker for the multichannel covariance matrix core: follows register writes, sums every
// accepted sample transfer and compares each result transfer with the predicted matrix entry.
// Depends on mccov_pkg for sizes and register indexes.
module mccov_checker import mccov_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_ch0_re,
    input  logic signed [SAMPLE_BITS-1:0] s_ch0_im,
    input  logic signed [SAMPLE_BITS-1:0] s_ch1_re,
    input  logic signed [SAMPLE_BITS-1:0] s_ch1_im,
    input  logic signed [SAMPLE_BITS-1:0] s_ch2_re,
    input  logic signed [SAMPLE_BITS-1:0] s_ch2_im,
    input  logic signed [SAMPLE_BITS-1:0] s_ch3_re,
    input  logic signed [SAMPLE_BITS-1:0] s_ch3_im,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [CH_BITS-1:0]            m_row,
    input  logic [CH_BITS-1:0]            m_col,
    input  logic signed [ACC_BITS-1:0]    m_sum_real,
    input  logic signed [ACC_BITS-1:0]    m_sum_imag,
    input  logic                          m_last_entry,
    output int                            fail_count,
    output int                            pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted entry of the covariance matrix.
    typedef struct {
        logic [CH_BITS-1:0]  row;
        logic [CH_BITS-1:0]  col;
        logic [ACC_BITS-1:0] sum_re;
        logic [ACC_BITS-1:0] sum_im;
        logic                last;
    } cov_entry_t;

    // Shadow of the configuration and of the window sums.
    logic [NCH_BITS-1:0]  chan_count;
    logic [WLEN_BITS-1:0] win_length;
    logic [ACC_BITS-1:0]  pair_re_sum [NUM_ENTRIES];
    logic [ACC_BITS-1:0]  pair_im_sum [NUM_ENTRIES];
    int                   win_fill;
    cov_entry_t           entry_q [$];

    task automatic clear_sums();
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            pair_re_sum[i] = '0;
            pair_im_sum[i] = '0;
        end
        win_fill = 0;
    endtask

    // Add x_a * conj(x_b) for every pair and, when the window closes, queue its matrix.
    task automatic absorb_sample(input logic signed [SAMPLE_BITS-1:0] xr [MAX_CHANNELS],
                                 input logic signed [SAMPLE_BITS-1:0] xi [MAX_CHANNELS]);
        longint     prod_re;
        longint     prod_im;
        int         e;
        int         nch;
        int         wlen;
        cov_entry_t ent;
        // All pairs are summed, also those of channels not in use.
        e = 0;
        for (int a = 0; a < MAX_CHANNELS; a++) begin
            for (int b = a; b < MAX_CHANNELS; b++) begin
                prod_re = longint'(xr[a]) * longint'(xr[b]) + longint'(xi[a]) * longint'(xi[b]);
                prod_im = longint'(xi[a]) * longint'(xr[b]) - longint'(xr[a]) * longint'(xi[b]);
                pair_re_sum[e] = pair_re_sum[e] + ACC_BITS'(prod_re);
                pair_im_sum[e] = pair_im_sum[e] + ACC_BITS'(prod_im);
                e++;
            end
        end
        win_fill++;
        // Register values out of range saturate to the supported span.
        wlen = (win_length == 0) ? 1 :
               (win_length > MAX_WINDOW) ? MAX_WINDOW : int'(win_length);
        if (win_fill < wlen) return;
        nch = (chan_count == 0) ? 1 :
              (chan_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_count);
        // Emit the used part of the upper triangle row by row; the last row holds one entry.
        e = 0;
        for (int a = 0; a < MAX_CHANNELS; a++) begin
            for (int b = a; b < MAX_CHANNELS; b++) begin
                if (b < nch) begin
                    ent.row    = CH_BITS'(a);
                    ent.col    = CH_BITS'(b);
                    ent.sum_re = pair_re_sum[e];
                    ent.sum_im = (a == b) ? '0 : pair_im_sum[e];
                    ent.last   = (a == nch - 1);
                    entry_q.push_back(ent);
                end
                e++;
            end
        end
        clear_sums();
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Everything is sampled at the rising edge, where transfers happen.
    always @(posedge aclk) begin
        logic signed [SAMPLE_BITS-1:0] xr [MAX_CHANNELS];
        logic signed [SAMPLE_BITS-1:0] xi [MAX_CHANNELS];
        cov_entry_t                    want;
        if (!aresetn) begin
            chan_count = NCH_RESET;
            win_length = WLEN_RESET;
            clear_sums();
            entry_q.delete();
        end else begin
            // Register writes change only the settings, never the sums.
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_CHAN_COUNT:    chan_count = cfg_wdata[NCH_BITS-1:0];
                    CFG_WINDOW_LENGTH: win_length = cfg_wdata[WLEN_BITS-1:0];
                    default: ;
                endcase
            end
            // A result transfer must match the oldest predicted entry.
            if (m_valid && m_ready) begin
                if (entry_q.size() == 0) begin
                    $error("unexpected result transfer: row %0d col %0d", m_row, m_col);
                    fail_count++;
                end else begin
                    want = entry_q.pop_front();
                    compare_field("row", want.row, m_row);
                    compare_field("col", want.col, m_col);
                    compare_field("sum_real", $signed(want.sum_re), m_sum_real);
                    compare_field("sum_imag", $signed(want.sum_im), m_sum_imag);
                    compare_field("last_entry", want.last, m_last_entry);
                end
            end
            // An accepted sample transfer feeds the prediction.
            if (s_valid && s_ready) begin
                xr[0] = s_ch0_re;
                xi[0] = s_ch0_im;
                xr[1] = s_ch1_re;
                xi[1] = s_ch1_im;
                xr[2] = s_ch2_re;
                xi[2] = s_ch2_im;
                xr[3] = s_ch3_re;
                xi[3] = s_ch3_im;
                absorb_sample(xr, xi);
            end
        end
        pending_count <= entry_q.size();
    end

endmodule

@@ test/tb_multichannel_covariance_matrix_core.sv @@
// Testbench top for multichannel_covariance_matrix_core: clock, reset, register writes,
// sample stimulus with random gaps and a randomly stalling result sink, and the verdict.
// Depends on mccov_pkg, the core and mccov_checker, which does all prediction and checking.
module tb_multichannel_covariance_matrix_core;
    import mccov_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES     = 12;
    localparam int SETTLE_CYCLES    = 16;
    localparam int SINK_HOLD_CYCLES = 200;
    localparam int TIMEOUT_NS       = 1_000_000;
    localparam int NUM_FIELDS       = 2 * MAX_CHANNELS;

    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_ONE = SAMPLE_BITS'(1);
    localparam logic [SAMPLE_BITS-1:0] SMP_NIL = '0;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]       cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_ch0_re;
    logic signed [SAMPLE_BITS-1:0] s_ch0_im;
    logic signed [SAMPLE_BITS-1:0] s_ch1_re;
    logic signed [SAMPLE_BITS-1:0] s_ch1_im;
    logic signed [SAMPLE_BITS-1:0] s_ch2_re;
    logic signed [SAMPLE_BITS-1:0] s_ch2_im;
    logic signed [SAMPLE_BITS-1:0] s_ch3_re;
    logic signed [SAMPLE_BITS-1:0] s_ch3_im;
    logic                          m_valid;
    logic                          m_ready;
    logic [CH_BITS-1:0]            m_row;
    logic [CH_BITS-1:0]            m_col;
    logic signed [ACC_BITS-1:0]    m_sum_real;
    logic signed [ACC_BITS-1:0]    m_sum_imag;
    logic                          m_last_entry;
    int                            fail_count;
    int                            pending_count;

    // No idling at all while calm is set; sink_hold_req asks the sink for one long stall.
    bit calm          = 1'b0;
    bit sink_hold_req = 1'b0;

    multichannel_covariance_matrix_core u_dut (.*);

    mccov_checker u_checker (.*);

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Watchdog for a block that stops moving.
    initial begin
        #(TIMEOUT_NS);
        $display("tb_multichannel_covariance_matrix_core: FAIL");
        $finish;
    end

    // Result sink: ready drops in short random bursts, or once for a long hold.
    initial begin
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                stall = SINK_HOLD_CYCLES;
            end else if (stall == 0 && !calm && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 4);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Both registers are written on consecutive cycles; called at a falling edge.
    task automatic write_config(input logic [CFG_DATA_BITS-1:0] nch_word,
                                input logic [CFG_DATA_BITS-1:0] wlen_word);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CHAN_COUNT;
        cfg_wdata <= nch_word;
        @(negedge aclk);
        cfg_index <= CFG_WINDOW_LENGTH;
        cfg_wdata <= wlen_word;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One sample transfer, possibly after a short gap; valid is left high for the next one.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] f [NUM_FIELDS]);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_ch0_re <= f[0];
        s_ch0_im <= f[1];
        s_ch1_re <= f[2];
        s_ch1_im <= f[3];
        s_ch2_re <= f[4];
        s_ch2_im <= f[5];
        s_ch3_re <= f[6];
        s_ch3_im <= f[7];
        s_valid  <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random field with a bias toward zero and the extremes of the sample range.
    function automatic logic [SAMPLE_BITS-1:0] pick_field();
        case ($urandom_range(0, 11))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return SMP_NIL;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        logic [SAMPLE_BITS-1:0] vec [NUM_FIELDS];
        repeat (count) begin
            foreach (vec[i]) vec[i] = pick_field();
            send_sample(vec);
        end
    endtask

    // Stop offering, let every expected entry arrive, then cover the pipeline latency.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [SAMPLE_BITS-1:0] vec [NUM_FIELDS];
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_CHAN_COUNT;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_ch0_re  = '0;
        s_ch0_im  = '0;
        s_ch1_re  = '0;
        s_ch1_im  = '0;
        s_ch2_re  = '0;
        s_ch2_im  = '0;
        s_ch3_re  = '0;
        s_ch3_im  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: one-sample windows, full matrix, extremes and sign of the cross terms.
        write_config(4, 1);
        vec = '{default: SMP_NIL};
        send_sample(vec);
        vec = '{default: SMP_MAX};
        send_sample(vec);
        vec = '{default: SMP_MIN};
        send_sample(vec);
        vec = '{SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX};
        send_sample(vec);
        vec = '{SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MIN, SMP_MAX};
        send_sample(vec);
        vec = '{SMP_NIL, SMP_ONE, SMP_ONE, SMP_NIL, SMP_NIL, SMP_NIL, SMP_NIL, SMP_NIL};
        send_sample(vec);
        vec = '{SMP_ONE, SMP_NIL, SMP_NIL, SMP_ONE, SMP_NIL, SMP_NIL, SMP_NIL, SMP_NIL};
        send_sample(vec);
        vec = '{default: '1};
        send_sample(vec);
        send_random(2);
        drain();

        // Zero channels and a zero window act as one of each.
        write_config(0, 0);
        vec = '{default: SMP_MAX};
        send_sample(vec);
        vec = '{default: SMP_MIN};
        send_sample(vec);
        drain();

        // A channel count above the maximum acts as the maximum.
        write_config(7, 3);
        send_random(30);
        drain();

        // Junk above the channel-count field; the sender pauses until all entries are out.
        write_config(13'h0F02, 5);
        send_random(20);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        send_random(20);
        drain();

        // Long sink hold while samples keep coming, so the core backs up to its input.
        write_config(4, 1);
        sink_hold_req = 1'b1;
        send_random(25);
        drain();

        write_config(3, 2);
        send_random(40);
        drain();

        write_config(1, 16);
        send_random(48);
        drain();

        // Oversized window, then a shorter one and fewer channels in the middle of it.
        write_config(4, 13'h1FFF);
        send_random(20);
        drain();
        write_config(2, 7);
        send_random(30);
        drain();

        // Largest window, then changed mid-window as well.
        write_config(5, 4096);
        send_random(15);
        drain();
        write_config(3, 4);
        send_random(21);
        drain();

        // Closing stretch at full rate on both sides.
        calm = 1'b1;
        write_config(4, 2);
        send_random(60);
        drain();

        if (fail_count == 0) begin
            $display("tb_multichannel_covariance_matrix_core: PASS");
        end else begin
            $display("tb_multichannel_covariance_matrix_core: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mccov_pkg.sv
rtl/mccov_lane.sv
rtl/multichannel_covariance_matrix_core.sv
test/mccov_checker.sv
test/tb_multichannel_covariance_matrix_core.sv
